FILE: sv/rhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// Types and constants shared by the RGB to HSV converter pipeline.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int CHAN_W      = 8;
   localparam int NUM_W       = 15;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int HUE_W       = 9;
   localparam int PCT_W       = 7;
   localparam int HCALC_W     = 10;
   localparam int DIV_LAT     = 4;
   localparam int PIPE_DEPTH  = 7;

   localparam logic [NUM_W-1:0]   HUE_SCALE  = 15'd60;
   localparam logic [NUM_W-1:0]   PCT_SCALE  = 15'd100;
   localparam logic [HCALC_W-1:0] HUE_GREEN  = 10'd120;
   localparam logic [HCALC_W-1:0] HUE_BLUE   = 10'd240;
   localparam logic [HCALC_W-1:0] HUE_FULL   = 10'd360;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      logic             gray;
      sector_type       sector;
      logic             neg;
      logic [PCT_W-1:0] val;
   } side_type;

endpackage

FILE: sv/rhc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_front
// Max/min, sector pick and scaled numerators; value percent. Two stages.
// ----------------------------------------------------------------------------
module rhc_front
   import rhc_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [CHAN_W-1:0] red,
   input  logic [CHAN_W-1:0] green,
   input  logic [CHAN_W-1:0] blue,
   output logic [NUM_W-1:0]  hue_num,
   output logic [CHAN_W-1:0] hue_den,
   output logic [NUM_W-1:0]  sat_num,
   output logic [CHAN_W-1:0] sat_den,
   output side_type          side
);

   logic [CHAN_W-1:0] mx_in, mn_in, d_in, mag_in;
   logic [CHAN_W-1:0] x_sel, y_sel;
   logic signed [CHAN_W:0] diff;
   sector_type        sector_in;
   logic              neg_in;

   logic [CHAN_W-1:0] mx_ff, d_ff, mag_ff;
   sector_type        sector_ff;
   logic              neg_ff;

   logic [NUM_W:0]    vnum;
   logic [NUM_W:0]    vsum;
   side_type          side_in;

   logic [NUM_W-1:0]  hue_num_ff, sat_num_ff;
   logic [CHAN_W-1:0] hue_den_ff, sat_den_ff;
   side_type          side_ff;

   always_comb begin
      mx_in = red;
      mn_in = red;
      if (green > mx_in) mx_in = green;
      if (blue > mx_in) mx_in = blue;
      if (green < mn_in) mn_in = green;
      if (blue < mn_in) mn_in = blue;
      d_in = mx_in - mn_in;
      if (red >= green && red >= blue) begin
         sector_in = SECTOR_RED;
         x_sel     = green;
         y_sel     = blue;
      end else if (green >= blue) begin
         sector_in = SECTOR_GREEN;
         x_sel     = blue;
         y_sel     = red;
      end else begin
         sector_in = SECTOR_BLUE;
         x_sel     = red;
         y_sel     = green;
      end
      diff   = $signed({1'b0, x_sel}) - $signed({1'b0, y_sel});
      neg_in = diff[CHAN_W];
      mag_in = neg_in ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff     <= mx_in;
         d_ff      <= d_in;
         mag_ff    <= mag_in;
         sector_ff <= sector_in;
         neg_ff    <= neg_in;
      end
   end

   // floor(v / 255) for v < 65535: (v + (v >> 8) + 1) >> 8
   always_comb begin
      vnum           = (NUM_W+1)'(mx_ff) * (NUM_W+1)'(PCT_SCALE);
      vsum           = vnum + (vnum >> 8) + (NUM_W+1)'(1);
      side_in.gray   = (d_ff == '0);
      side_in.sector = sector_ff;
      side_in.neg    = neg_ff;
      side_in.val    = PCT_W'(vsum >> 8);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_num_ff <= NUM_W'(mag_ff) * HUE_SCALE;
         sat_num_ff <= NUM_W'(d_ff) * PCT_SCALE;
         hue_den_ff <= d_ff;
         sat_den_ff <= mx_ff;
         side_ff    <= side_in;
      end
   end

   assign hue_num = hue_num_ff;
   assign hue_den = hue_den_ff;
   assign sat_num = sat_num_ff;
   assign sat_den = sat_den_ff;
   assign side    = side_ff;

endmodule

FILE: sv/rhc_divide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_divide
// Four-stage reciprocal divider: table lookup, multiply, back-multiply,
// one-step correction. Gives floor(num/den) and a nonzero-remainder flag.
// ----------------------------------------------------------------------------
module rhc_divide
   import rhc_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [NUM_W-1:0]  num,
   input  logic [CHAN_W-1:0] den,
   output logic [NUM_W-1:0]  quo,
   output logic              rem_nz
);

   localparam int TAB_N = 1 << CHAN_W;

   logic [RECIP_W-1:0] recip_tab [TAB_N];

   for (genvar i = 0; i < TAB_N; i++) begin : g_recip
      localparam logic [RECIP_W-1:0] RECIP = (i == 0) ? '0 :
         RECIP_W'((1 << RECIP_SHIFT) / ((i == 0) ? 1 : i));
      assign recip_tab[i] = RECIP;
   end

   logic [NUM_W-1:0]   num1_ff, num2_ff, num3_ff;
   logic [CHAN_W-1:0]  den1_ff, den2_ff, den3_ff;
   logic [RECIP_W-1:0] recip1_ff;
   logic [NUM_W-1:0]   qe2_ff, qe3_ff, back3_ff;
   logic [NUM_W-1:0]   quo_ff;
   logic               rem_nz_ff;

   logic [NUM_W+RECIP_W-1:0] prod;
   logic [NUM_W+CHAN_W-1:0]  back_full;
   logic [NUM_W-1:0]         rem;
   logic                     fix;

   assign prod      = (NUM_W+RECIP_W)'(num1_ff) * (NUM_W+RECIP_W)'(recip1_ff);
   assign back_full = (NUM_W+CHAN_W)'(qe2_ff) * (NUM_W+CHAN_W)'(den2_ff);
   assign rem       = num3_ff - back3_ff;
   assign fix       = (rem >= NUM_W'(den3_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         num1_ff   <= num;
         den1_ff   <= den;
         recip1_ff <= recip_tab[den];

         qe2_ff    <= prod[RECIP_SHIFT +: NUM_W];
         num2_ff   <= num1_ff;
         den2_ff   <= den1_ff;

         qe3_ff    <= qe2_ff;
         back3_ff  <= back_full[NUM_W-1:0];
         num3_ff   <= num2_ff;
         den3_ff   <= den2_ff;

         quo_ff    <= qe3_ff + NUM_W'(fix);
         rem_nz_ff <= fix ? (rem != NUM_W'(den3_ff)) : (rem != '0);
      end
   end

   assign quo    = quo_ff;
   assign rem_nz = rem_nz_ff;

endmodule

FILE: sv/rhc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_back
// Hue assembly from sector base and floored quotient; output registers.
// ----------------------------------------------------------------------------
module rhc_back
   import rhc_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  side_type          side,
   input  logic [NUM_W-1:0]  hue_q,
   input  logic              hue_nz,
   input  logic [NUM_W-1:0]  sat_q,
   output logic [HUE_W-1:0]  hue,
   output logic [PCT_W-1:0]  sat,
   output logic [PCT_W-1:0]  bright
);

   logic [HCALC_W-1:0] base;
   logic [HCALC_W-1:0] qmag;
   logic [HCALC_W-1:0] h_sum;
   logic [HUE_W-1:0]   hue_in;
   logic [PCT_W-1:0]   sat_in;

   logic [HUE_W-1:0]   hue_ff;
   logic [PCT_W-1:0]   sat_ff, bright_ff;

   always_comb begin
      case (side.sector)
         SECTOR_RED:   base = '0;
         SECTOR_GREEN: base = HUE_GREEN;
         SECTOR_BLUE:  base = HUE_BLUE;
         default:      base = '0;
      endcase
      qmag = HCALC_W'(hue_q);
      // negative quotient floors toward minus infinity
      if (side.neg) h_sum = base - qmag - HCALC_W'(hue_nz);
      else          h_sum = base + qmag;
      if (h_sum[HCALC_W-1]) h_sum = h_sum + HUE_FULL;
      hue_in = side.gray ? '0 : h_sum[HUE_W-1:0];
      sat_in = side.gray ? '0 : sat_q[PCT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= side.val;
      end
   end

   assign hue    = hue_ff;
   assign sat    = sat_ff;
   assign bright = bright_ff;

endmodule

FILE: sv/rgb_to_hsv_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// Converts an 8-bit RGB pixel to integer hue degrees, saturation and value %.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_*: one pixel item per accepted cycle (req_valid high,
//   req_stall low). Result channel rsp_*: one item per pixel, in order.
//   The path from acceptance to rsp_valid runs through
//   two front stages (max/min, numerators), four divider stages
//   (reciprocal lookup, multiply, back-multiply, correction) and one
//   output stage. Throughput is one item per clock unless rsp_stall holds a result.
//   When the receiver holds rsp_stall with rsp_valid high, the whole
//   pipeline freezes, the result holds, and req_stall goes high in the
//   same cycle; nothing is dropped or duplicated. Empty stages still
//   move while rsp_valid is low.
//   Synchronous reset clears all valid bits; no result follows reset
//   until new pixels are accepted. There is no configuration.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core
   import rhc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAN_W-1:0] req_red_level,
   input  logic [CHAN_W-1:0] req_green_level,
   input  logic [CHAN_W-1:0] req_blue_level,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [HUE_W-1:0]  rsp_hue_degrees,
   output logic [PCT_W-1:0]  rsp_saturation_percent,
   output logic [PCT_W-1:0]  rsp_brightness_percent
);

   logic                  en;
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;

   logic [NUM_W-1:0]  hue_num, sat_num, hue_q, sat_q;
   logic [CHAN_W-1:0] hue_den, sat_den;
   logic              hue_nz, sat_nz;
   side_type          side_front;
   side_type          side_ff [DIV_LAT];

   assign en        = !(valid_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = valid_ff[PIPE_DEPTH-1];
   assign valid_in  = {valid_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_front;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   rhc_front u_front (
      .clock   (clock),
      .en      (en),
      .red     (req_red_level),
      .green   (req_green_level),
      .blue    (req_blue_level),
      .hue_num (hue_num),
      .hue_den (hue_den),
      .sat_num (sat_num),
      .sat_den (sat_den),
      .side    (side_front)
   );

   rhc_divide u_hue_div (
      .clock  (clock),
      .en     (en),
      .num    (hue_num),
      .den    (hue_den),
      .quo    (hue_q),
      .rem_nz (hue_nz)
   );

   rhc_divide u_sat_div (
      .clock  (clock),
      .en     (en),
      .num    (sat_num),
      .den    (sat_den),
      .quo    (sat_q),
      .rem_nz (sat_nz)
   );

   rhc_back u_back (
      .clock  (clock),
      .en     (en),
      .side   (side_ff[DIV_LAT-1]),
      .hue_q  (hue_q),
      .hue_nz (hue_nz),
      .sat_q  (sat_nz ? sat_q : sat_q),
      .hue    (rsp_hue_degrees),
      .sat    (rsp_saturation_percent),
      .bright (rsp_brightness_percent)
   );

endmodule

FILE: sv/rhc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks for the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhc_checker
   import rhc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [CHAN_W-1:0] req_red_level,
   input logic [CHAN_W-1:0] req_green_level,
   input logic [CHAN_W-1:0] req_blue_level,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [HUE_W-1:0]  rsp_hue_degrees,
   input logic [PCT_W-1:0]  rsp_saturation_percent,
   input logic [PCT_W-1:0]  rsp_brightness_percent
);

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hue_degrees)
         && $stable(rsp_saturation_percent) && $stable(rsp_brightness_percent))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item shown right after reset");

   a_no_input_block: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("input stalled with no stalled result");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue_degrees < 9'd360 && rsp_saturation_percent <= 7'd100
         && rsp_brightness_percent <= 7'd100)
      else $error("result field out of range");

endmodule

bind rgb_to_hsv_converter_core rhc_checker u_rhc_checker (.*);
